// ===== rtl/lerw_pkg.sv =====
// lerw_pkg: shared constants and types of the lattice edge row walker
// no dependencies; imported by lerw_div and lattice_edge_row_walker_core
package lerw_pkg;

   localparam int X_WIDTH_DEF   = 12;
   localparam int ROW_COUNT_DEF = 64;
   localparam int ROW_W         = 6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_WALK,
      ST_HEND
   } lerw_state_type;

endpackage

// ===== rtl/lerw_div.sv =====
// lerw_div: restoring divider, one quotient bit per cycle
// depends on lerw_pkg for the row width
module lerw_div #(
   parameter int X_WIDTH = lerw_pkg::X_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [X_WIDTH-1:0]         dividend,
   input  logic [lerw_pkg::ROW_W-1:0] divisor,
   output logic                       done,
   output logic [X_WIDTH-1:0]         quotient,
   output logic [lerw_pkg::ROW_W-1:0] remainder
);
   import lerw_pkg::*;

   localparam int CNT_W = $clog2(X_WIDTH + 1);

   logic [X_WIDTH-1:0] quo_ff, quo_in;
   logic [ROW_W-1:0]   rem_ff, rem_in;
   logic [ROW_W-1:0]   dvs_ff, dvs_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [ROW_W:0]     partial;
   logic [ROW_W:0]     diff;
   logic               fits;

   // shift in the next dividend bit and try the subtraction
   assign partial = {rem_ff, quo_ff[X_WIDTH-1]};
   assign diff    = partial - {1'b0, dvs_ff};
   assign fits    = !diff[ROW_W];

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(X_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[X_WIDTH-2:0], fits};
         rem_in = fits ? diff[ROW_W-1:0] : partial[ROW_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/lattice_edge_row_walker_core.sv =====
// lattice_edge_row_walker_core: top level of the lattice edge row walker
// depends on lerw_pkg and lerw_div
//
// Walks one edge from (req_start_x, req_start_y) to (req_end_x, req_end_y) and
// sends the lattice points it visits, one per row from the start row to the
// end row inclusive, each on the rsp_ ports for a single cycle under
// rsp_strobe; the final point of a run carries rsp_last_point. A horizontal
// edge gives its two endpoints, a zero-length edge gives nothing at all (no
// strobe and no last marker, so watch busy to know the edge is finished).
// Rows above ROW_COUNT-1 are clamped. The receiver cannot hold results off:
// it must take every strobed transfer. An edge is taken when start is high
// and busy is low; busy drops in the cycle the last point is on the ports,
// so the next edge can be taken at the edge that takes that point.
// One edge of row span |dy| > 0 goes from the transfer to the edge that takes
// the last point through the set-up state, the bit-serial divider that splits
// |dx| by |dy| into a whole column step and a remainder, a hand-over while the
// divider's done flag is registered, one row per cycle, and the output
// register. A horizontal edge sends its start point from the set-up state and
// its end point from ST_HEND; a zero-length edge is busy only in set-up.
module lattice_edge_row_walker_core #(
   parameter int X_WIDTH   = lerw_pkg::X_WIDTH_DEF,
   parameter int ROW_COUNT = lerw_pkg::ROW_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [X_WIDTH-1:0]         req_start_x,
   input  logic        [lerw_pkg::ROW_W-1:0] req_start_y,
   input  logic signed [X_WIDTH-1:0]         req_end_x,
   input  logic        [lerw_pkg::ROW_W-1:0] req_end_y,
   output logic                              rsp_strobe,
   output logic signed [X_WIDTH-1:0]         rsp_point_x,
   output logic        [lerw_pkg::ROW_W-1:0] rsp_point_y,
   output logic                              rsp_last_point
);
   import lerw_pkg::*;

   localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROW_COUNT - 1);

   lerw_state_type state_ff, state_in;

   // captured edge, rows already clamped
   logic [X_WIDTH-1:0] x0_ff, x0_in;
   logic [X_WIDTH-1:0] x1_ff, x1_in;
   logic [ROW_W-1:0]   y0_ff, y0_in;
   logic [ROW_W-1:0]   y1_ff, y1_in;

   // walk state
   logic [X_WIDTH-1:0] x_ff, x_in;
   logic [ROW_W-1:0]   y_ff, y_in;
   logic [ROW_W-1:0]   err_ff, err_in;     // m*|dy| - k*|dx| - t0, kept in 0..|dy|-1
   logic [ROW_W-1:0]   ady_ff, ady_in;
   logic [ROW_W-1:0]   left_ff, left_in;   // rows still to go after this one
   logic               xneg_ff, xneg_in;
   logic               yneg_ff, yneg_in;

   // result registers
   logic               strobe_ff, strobe_in;
   logic [X_WIDTH-1:0] px_ff, px_in;
   logic [ROW_W-1:0]   py_ff, py_in;
   logic               plast_ff, plast_in;

   // set-up arithmetic on the captured edge
   logic [X_WIDTH:0]   dx_fwd, dx_rev;
   logic               dx_neg, dx_zero;
   logic [X_WIDTH-1:0] adx;
   logic               dy_neg, dy_zero;
   logic [ROW_W-1:0]   ady;
   logic               same_sign;

   // divider
   logic               div_start, div_done;
   logic [X_WIDTH-1:0] div_quo;
   logic [ROW_W-1:0]   div_rem;

   // one row step
   logic [ROW_W:0]     err_sub;
   logic               carry;
   logic [X_WIDTH-1:0] x_step;

   assign busy = (state_ff != ST_IDLE);

   // both differences in parallel, pick the non-negative one
   assign dx_fwd  = {x1_ff[X_WIDTH-1], x1_ff} - {x0_ff[X_WIDTH-1], x0_ff};
   assign dx_rev  = {x0_ff[X_WIDTH-1], x0_ff} - {x1_ff[X_WIDTH-1], x1_ff};
   assign dx_neg  = dx_fwd[X_WIDTH];
   assign dx_zero = (x0_ff == x1_ff);
   assign adx     = dx_neg ? dx_rev[X_WIDTH-1:0] : dx_fwd[X_WIDTH-1:0];

   assign dy_neg  = (y1_ff < y0_ff);
   assign dy_zero = (y1_ff == y0_ff);
   assign ady     = dy_neg ? (y0_ff - y1_ff) : (y1_ff - y0_ff);

   // edge rises or falls with x: threshold offset is zero
   assign same_sign = !dx_zero && (dx_neg == dy_neg);

   assign div_start = (state_ff == ST_SETUP) && !dy_zero;

   lerw_div #(
      .X_WIDTH (X_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (adx),
      .divisor   (ady),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // error term loses the remainder each row; a borrow costs one extra column
   assign err_sub = {1'b0, err_ff} - {1'b0, div_rem};
   assign carry   = err_sub[ROW_W];
   assign x_step  = div_quo + {{(X_WIDTH-1){1'b0}}, carry};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            if (dy_zero) begin
               state_in = dx_zero ? ST_IDLE : ST_HEND;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (left_ff == '0) state_in = ST_IDLE;
         end
         ST_HEND: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and results
   always_comb begin
      x0_in     = x0_ff;
      x1_in     = x1_ff;
      y0_in     = y0_ff;
      y1_in     = y1_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      err_in    = err_ff;
      ady_in    = ady_ff;
      left_in   = left_ff;
      xneg_in   = xneg_ff;
      yneg_in   = yneg_ff;
      strobe_in = 1'b0;
      px_in     = px_ff;
      py_in     = py_ff;
      plast_in  = plast_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // capture on the input transfer, clamping rows
            if (start) begin
               x0_in = req_start_x;
               x1_in = req_end_x;
               y0_in = (req_start_y > ROW_MAX) ? ROW_MAX : req_start_y;
               y1_in = (req_end_y > ROW_MAX) ? ROW_MAX : req_end_y;
            end
         end
         ST_SETUP: begin
            x_in    = x0_ff;
            y_in    = y0_ff;
            ady_in  = ady;
            left_in = ady;
            xneg_in = dx_neg;
            yneg_in = dy_neg;
            err_in  = same_sign ? '0 : (ady - 1'b1);
            // horizontal edge: start point now, end point next cycle
            if (dy_zero && !dx_zero) begin
               strobe_in = 1'b1;
               px_in     = x0_ff;
               py_in     = y0_ff;
               plast_in  = 1'b0;
            end
         end
         ST_DIV: begin
         end
         ST_WALK: begin
            strobe_in = 1'b1;
            px_in     = x_ff;
            py_in     = y_ff;
            plast_in  = (left_ff == '0);
            left_in   = left_ff - 1'b1;
            err_in    = carry ? (err_sub[ROW_W-1:0] + ady_ff) : err_sub[ROW_W-1:0];
            x_in      = xneg_ff ? (x_ff - x_step) : (x_ff + x_step);
            y_in      = yneg_ff ? (y_ff - 1'b1) : (y_ff + 1'b1);
         end
         ST_HEND: begin
            strobe_in = 1'b1;
            px_in     = x1_ff;
            py_in     = y1_ff;
            plast_in  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      x0_ff    <= x0_in;
      x1_ff    <= x1_in;
      y0_ff    <= y0_in;
      y1_ff    <= y1_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      err_ff   <= err_in;
      ady_ff   <= ady_in;
      left_ff  <= left_in;
      xneg_ff  <= xneg_in;
      yneg_ff  <= yneg_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      plast_ff <= plast_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_point_x    = px_ff;
   assign rsp_point_y    = py_ff;
   assign rsp_last_point = plast_ff;

endmodule

// ===== sim/tb_lattice_edge_row_walker_core.sv =====
// tb_lattice_edge_row_walker_core: self-checking bench for the lattice edge row walker
// depends on lerw_pkg and lattice_edge_row_walker_core; edges are paced in random bursts
// and every strobed point is checked against an in-bench integer walk of the same edge
module tb_lattice_edge_row_walker_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int X_W       = lerw_pkg::X_WIDTH_DEF;
   localparam int ROW_COUNT = lerw_pkg::ROW_COUNT_DEF;
   localparam int ROW_W     = lerw_pkg::ROW_W;

   // the longest gap the sender leaves between bursts
   localparam int GAP_MAX     = 90;
   localparam int TAIL_CYCLES = X_W + ROW_COUNT + 16;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_EDGES = 400;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [X_W-1:0]   x;
      logic [ROW_W-1:0] y;
      logic             is_last;
   } lattice_point_type;

   // clock and stimulus, all known from time zero
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic signed [X_W-1:0]   req_start_x = '0;
   logic        [ROW_W-1:0] req_start_y = '0;
   logic signed [X_W-1:0]   req_end_x = '0;
   logic        [ROW_W-1:0] req_end_y = '0;

   logic                    busy;
   logic                    rsp_strobe;
   logic signed [X_W-1:0]   rsp_point_x;
   logic        [ROW_W-1:0] rsp_point_y;
   logic                    rsp_last_point;

   // points still owed by the block, oldest first
   lattice_point_type pending_points[$];

   int mismatch_count = 0;
   int points_checked = 0;
   int edges_sent     = 0;
   int flat_edges     = 0;
   int upright_edges  = 0;
   int null_edges     = 0;
   int cycle_count    = 0;
   int burst_left     = 0;

   lattice_edge_row_walker_core #(
      .X_WIDTH   (X_W),
      .ROW_COUNT (ROW_COUNT)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .rsp_strobe     (rsp_strobe),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_last_point (rsp_last_point)
   );

   always #2 clock = ~clock;

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d points still owed",
                  cycle_count, pending_points.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // clamp a row to the lattice
   function automatic int clamp_row(input logic [ROW_W-1:0] r);
      int v;
      v = int'(r);
      if (v > ROW_COUNT - 1) v = ROW_COUNT - 1;
      return v;
   endfunction

   function automatic int sign_int(input int v);
      if (v > 0) return 1;
      if (v < 0) return -1;
      return 0;
   endfunction

   // integer walk of one edge: queues every point it will emit
   function automatic void predict_edge_points(input logic signed [X_W-1:0]   x_a,
                                               input logic        [ROW_W-1:0] y_a,
                                               input logic signed [X_W-1:0]   x_b,
                                               input logic        [ROW_W-1:0] y_b);
      int x0, y0, x1, y1, dx, dy, step_x, step_y, adx, ady, bias, acc, col_step, px, py;
      lattice_point_type p;
      x0 = int'(x_a);
      x1 = int'(x_b);
      y0 = clamp_row(y_a);
      y1 = clamp_row(y_b);
      dx = x1 - x0;
      dy = y1 - y0;
      step_x = sign_int(dx);
      step_y = sign_int(dy);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;

      if (dy == 0) begin
         // flat edge: both endpoints, even on the same row; zero length: nothing
         if (dx == 0) begin
            null_edges++;
            return;
         end
         flat_edges++;
         p.x = x0[X_W-1:0];
         p.y = y0[ROW_W-1:0];
         p.is_last = 1'b0;
         pending_points = {pending_points, p};
         p.x = x1[X_W-1:0];
         p.y = y1[ROW_W-1:0];
         p.is_last = 1'b1;
         pending_points = {pending_points, p};
         return;
      end
      if (dx == 0) upright_edges++;

      // threshold moves with the edge direction so rising and falling edges agree
      bias = (step_x * step_y > 0) ? 0 : 1 - ady;
      for (int k = 0; k <= ady; k++) begin
         acc = bias + k * adx;
         col_step = (acc <= 0) ? 0 : (acc + ady - 1) / ady;
         px = x0 + step_x * col_step;
         py = y0 + step_y * k;
         p.x = px[X_W-1:0];
         p.y = py[ROW_W-1:0];
         p.is_last = (k == ady);
         pending_points = {pending_points, p};
      end
   endfunction

   // result checker: the receiver takes every strobed transfer
   always @(posedge clock) begin
      lattice_point_type want;
      if (!reset && rsp_strobe) begin
         if (pending_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected point x=%0d y=%0d last=%0b at cycle %0d",
                        rsp_point_x, rsp_point_y, rsp_last_point, cycle_count);
         end else begin
            want = pending_points.pop_front();
            points_checked++;
            if (rsp_point_x !== want.x || rsp_point_y !== want.y ||
                rsp_last_point !== want.is_last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"point mismatch at cycle %0d: want x=%0d y=%0d last=%0b,",
                            " got x=%0d y=%0d last=%0b"},
                           cycle_count, $signed(want.x), want.y, want.is_last,
                           rsp_point_x, rsp_point_y, rsp_last_point);
            end
         end
      end
   end

   // one edge transfer; start is left high so a burst can follow straight on
   task automatic send_edge(input int x_a, input int y_a, input int x_b, input int y_b);
      logic signed [X_W-1:0]   xa_v, xb_v;
      logic        [ROW_W-1:0] ya_v, yb_v;
      xa_v = X_W'(x_a);
      ya_v = ROW_W'(y_a);
      xb_v = X_W'(x_b);
      yb_v = ROW_W'(y_b);
      start       <= 1'b1;
      req_start_x <= xa_v;
      req_start_y <= ya_v;
      req_end_x   <= xb_v;
      req_end_y   <= yb_v;
      do @(posedge clock); while (busy);
      // taken at this edge
      predict_edge_points(xa_v, ya_v, xb_v, yb_v);
      edges_sent++;
   endtask

   // bursts of back-to-back edges with random gaps between them
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = int'($urandom_range(1, GAP_MAX));
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         // now and then a long stretch with no idling at all
         burst_left = ($urandom_range(0, 5) == 0) ? int'($urandom_range(30, 60))
                                                  : int'($urandom_range(0, 12));
      end
   endtask

   // sender holds off until the block owes nothing and has gone idle
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_points.size() != 0 || busy);
   endtask

   function automatic int rand_col();
      return int'($urandom_range(0, (1 << X_W) - 1)) - (1 << (X_W - 1));
   endfunction

   function automatic int rand_row();
      return int'($urandom_range(0, ROW_COUNT - 1));
   endfunction

   // corners of the coordinate range, walked in all four directions
   task automatic test_endpoint_extremes();
      send_edge(-2048, 0, 2047, 63);
      pace_sender();
      send_edge(2047, 63, -2048, 0);
      pace_sender();
      send_edge(2047, 0, -2048, 63);
      pace_sender();
      send_edge(-2048, 63, 2047, 0);
      wait_for_drain();
   endtask

   task automatic test_vertical_edges();
      send_edge(5, 0, 5, 63);
      pace_sender();
      send_edge(-2048, 63, -2048, 0);
      pace_sender();
      send_edge(2047, 10, 2047, 11);
      wait_for_drain();
   endtask

   // two points on one row, end point marked last
   task automatic test_horizontal_edges();
      send_edge(-2048, 7, 2047, 7);
      pace_sender();
      send_edge(100, 0, 99, 0);
      pace_sender();
      send_edge(0, 63, 1, 63);
      wait_for_drain();
   endtask

   // zero-length edges give no strobe at all, busy alone tells the edge is done; one diagonal step follows
   task automatic test_zero_length_edges();
      send_edge(0, 0, 0, 0);
      send_edge(-2048, 63, -2048, 63);
      pace_sender();
      send_edge(2047, 31, 2047, 31);
      send_edge(3, 3, 4, 4);
      wait_for_drain();
   endtask

   // x-major in each sign combination, y-major rising and falling, and single diagonal steps
   task automatic test_slope_octants();
      send_edge(0, 0, 40, 5);
      send_edge(0, 0, -40, 5);
      pace_sender();
      send_edge(40, 5, 0, 0);
      send_edge(-40, 5, 0, 0);
      send_edge(0, 10, 3, 40);
      pace_sender();
      send_edge(0, 40, -3, 10);
      send_edge(0, 0, 1, 1);
      send_edge(0, 1, 1, 0);
      wait_for_drain();
   endtask

   task automatic test_random_edges();
      int x_a, y_a, x_b, y_b;
      int pick;
      for (int n = 0; n < RANDOM_EDGES; n++) begin
         x_a  = rand_col();
         y_a  = rand_row();
         x_b  = rand_col();
         y_b  = rand_row();
         pick = int'($urandom_range(0, 99));
         if (pick < 10) begin
            x_b = x_a;                                 // vertical
         end else if (pick < 20) begin
            y_b = y_a;                                 // horizontal
         end else if (pick < 25) begin
            x_b = x_a;                                 // zero length
            y_b = y_a;
         end else if (pick < 45) begin
            // short edges near the start point, small slopes both ways
            x_b = x_a + int'($urandom_range(0, 16)) - 8;
            y_b = (y_a > 55) ? y_a - int'($urandom_range(0, 8))
                             : y_a + int'($urandom_range(0, 8));
         end
         send_edge(x_a, y_a, x_b, y_b);
         // full pause halfway through
         if (n == RANDOM_EDGES / 2) wait_for_drain();
         else pace_sender();
      end
      wait_for_drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_endpoint_extremes();
      test_vertical_edges();
      test_horizontal_edges();
      test_zero_length_edges();
      test_slope_octants();
      test_random_edges();

      // let any stray strobe show itself
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("edges sent %0d (vertical %0d, horizontal %0d, zero length %0d)",
               edges_sent, upright_edges, flat_edges, null_edges);
      $display("points checked %0d, mismatches %0d, points still owed %0d, cycles %0d",
               points_checked, mismatch_count, pending_points.size(), cycle_count);
      if (mismatch_count == 0 && pending_points.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
